### hw/rtl/xtea_pkg.sv
// Shared types and constants for the XTEA block cipher core.
// Used by xtea_stage, xtea_block_cipher_core and the testbench; depends on nothing else.

package xtea_pkg;

  localparam logic [31:0] XteaDelta = 32'h9E37_79B9;
  localparam int unsigned CfgIdxW   = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord1 = 8'd1;
  localparam logic [CfgIdxW-1:0] RegKeyWord2 = 8'd2;
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = 8'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } req_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } rsp_t;

  typedef logic [3:0][31:0] key_t;

  // One pipeline slot: the block halves travel with their direction and valid bit.
  typedef struct packed {
    logic        valid;
    logic        dir;
    logic [31:0] v0;
    logic [31:0] v1;
  } stage_t;

endpackage

### hw/rtl/xtea_block_cipher_core.sv
// Top level of the XTEA block cipher core: key registers and the half-round pipeline.
// Depends on xtea_pkg and xtea_stage.
//
// Usage:
//   Input: a block transfer happens at a rising edge with start high and busy low.
//   busy stays low, so one block (req_type, word_first, word_second) may be
//   given every cycle; encipher and decipher blocks mix freely.
//   Output: the transformed block is on rsp_o for exactly one cycle while done_o
//   is high, once it has passed through all 2*ROUNDS registered pipeline stages.
//   Results leave in input order. The receiver cannot stall the core.
//   Throughput is one block per cycle; each of the 2*ROUNDS pipeline stages
//   holds one half-round (three 32-bit adds or subtracts and two xors between registers).
//   Configuration: cfg_ready_o is always high. Index 0..3 writes key word 0..3,
//   other indexes are ignored. Write keys only while no block is in flight.
//   Reset: clears the key words to zero and empties the pipeline; blocks in
//   flight are dropped and no done_o is raised for them.

module xtea_block_cipher_core #(
  parameter int unsigned ROUNDS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  xtea_pkg::req_t                req_i,
  output logic                          done_o,
  output xtea_pkg::rsp_t                rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned Depth = 2 * ROUNDS;

  xtea_pkg::key_t   key_q;
  xtea_pkg::key_t   key_d;
  xtea_pkg::stage_t chain [0:Depth];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        xtea_pkg::RegKeyWord0: key_d[0] = cfg_data_i;
        xtea_pkg::RegKeyWord1: key_d[1] = cfg_data_i;
        xtea_pkg::RegKeyWord2: key_d[2] = cfg_data_i;
        xtea_pkg::RegKeyWord3: key_d[3] = cfg_data_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign chain[0].valid = start && !busy;
  assign chain[0].dir   = req_i.req_type;
  assign chain[0].v0    = req_i.word_first;
  assign chain[0].v1    = req_i.word_second;

  for (genvar k = 0; k < Depth; k++) begin : g_stage
    xtea_stage #(
      .ROUNDS(ROUNDS),
      .STAGE (k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .stage_i(chain[k]),
      .stage_o(chain[k+1])
    );
  end

  assign done_o              = chain[Depth].valid;
  assign rsp_o.result_first  = chain[Depth].v0;
  assign rsp_o.result_second = chain[Depth].v1;

  // A result appears only for a block that entered the full pipeline depth earlier.
  a_done_has_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Depth))
    else $error("result strobe without a matching input transfer");

  // Every accepted block comes out after the full pipeline depth.
  a_input_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Depth done_o)
    else $error("accepted block did not produce a result on time");

  // Writes to indexes outside the key words leave the key untouched.
  a_bad_idx_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_idx_i != xtea_pkg::RegKeyWord0 &&
     cfg_idx_i != xtea_pkg::RegKeyWord1 && cfg_idx_i != xtea_pkg::RegKeyWord2 &&
     cfg_idx_i != xtea_pkg::RegKeyWord3) |=> $stable(key_q))
    else $error("key changed on a write to an unused index");

endmodule

### hw/rtl/xtea_stage.sv
// One XTEA half-round as a registered pipeline stage.
// Depends on xtea_pkg for the stage and key types and the round delta.

module xtea_stage #(
  parameter int unsigned ROUNDS = 64,
  parameter int unsigned STAGE  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xtea_pkg::key_t    key_i,
  input  xtea_pkg::stage_t  stage_i,
  output xtea_pkg::stage_t  stage_o
);

  // Round sums are fixed per stage, so both directions are elaboration constants.
  localparam int unsigned Half   = (STAGE + 1) / 2;
  localparam logic        Odd    = 1'(STAGE % 2);
  localparam logic [31:0] SumEnc = 32'(64'(xtea_pkg::XteaDelta) * 64'(Half));
  localparam logic [31:0] SumDec = 32'(64'(xtea_pkg::XteaDelta) * 64'(ROUNDS - Half));

  function automatic logic [31:0] mix(input logic [31:0] x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

  logic        upd0;
  logic [31:0] sum;
  logic [1:0]  kidx;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] rk;
  logic [31:0] f;
  logic [31:0] res;
  logic        valid_q;
  logic        dir_q;
  logic [31:0] v0_d, v0_q;
  logic [31:0] v1_d, v1_q;

  // Encipher updates v0 on even stages; decipher runs the rounds backward
  // and therefore updates v0 on odd stages.
  always_comb begin
    upd0 = ~(stage_i.dir ^ Odd);
    sum  = stage_i.dir ? SumDec : SumEnc;
    kidx = upd0 ? sum[1:0] : sum[12:11];
    src  = upd0 ? stage_i.v1 : stage_i.v0;
    tgt  = upd0 ? stage_i.v0 : stage_i.v1;
    rk   = sum + key_i[kidx];
    f    = mix(src) ^ rk;
    res  = stage_i.dir ? (tgt - f) : (tgt + f);
    v0_d = upd0 ? res : stage_i.v0;
    v1_d = upd0 ? stage_i.v1 : res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= stage_i.dir;
    v0_q  <= v0_d;
    v1_q  <= v1_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.dir   = dir_q;
  assign stage_o.v0    = v0_q;
  assign stage_o.v1    = v1_q;

endmodule

### tb/tb_xtea_block_cipher_core.sv
// Self-checking testbench for xtea_block_cipher_core: directed and random ECB blocks.
// A local XTEA predictor holds its own copy of the key words.
// Depends on xtea_pkg and the core RTL only.

module tb_xtea_block_cipher_core;

  localparam int unsigned Rounds    = 64;
  localparam int unsigned Latency   = 2 * Rounds;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned RandItems = 1100;
  localparam int unsigned Phases    = 10;
  localparam logic        DirEncipher = 1'b0;
  localparam logic        DirDecipher = 1'b1;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  xtea_pkg::req_t                req_i;
  logic                          done_o;
  xtea_pkg::rsp_t                rsp_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [xtea_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [31:0]                   cfg_data_i;

  logic [31:0]    key_words [4];
  xtea_pkg::rsp_t expected_blocks [$];
  logic [63:0]    recent_cipher [$];
  xtea_pkg::rsp_t want;
  int unsigned    n_errors;
  int unsigned    n_checked;
  int unsigned    n_encipher;
  int unsigned    n_decipher;
  int unsigned    n_key_writes;
  int unsigned    n_cycles;

  xtea_block_cipher_core #(
    .ROUNDS(Rounds)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleCap) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Full XTEA over all rounds with the current key words.
  function automatic xtea_pkg::rsp_t xtea_transform(input xtea_pkg::req_t blk);
    logic [31:0]    y;
    logic [31:0]    z;
    logic [31:0]    acc;
    xtea_pkg::rsp_t res;
    y = blk.word_first;
    z = blk.word_second;
    if (blk.req_type == DirEncipher) begin
      acc = '0;
      for (int unsigned r = 0; r < Rounds; r++) begin
        y = y + ((((z << 4) ^ (z >> 5)) + z) ^ (acc + key_words[acc[1:0]]));
        acc = acc + xtea_pkg::XteaDelta;
        z = z + ((((y << 4) ^ (y >> 5)) + y) ^ (acc + key_words[acc[12:11]]));
      end
    end else begin
      acc = xtea_pkg::XteaDelta * 32'(Rounds);
      for (int unsigned r = 0; r < Rounds; r++) begin
        z = z - ((((y << 4) ^ (y >> 5)) + y) ^ (acc + key_words[acc[12:11]]));
        acc = acc - xtea_pkg::XteaDelta;
        y = y - ((((z << 4) ^ (z >> 5)) + z) ^ (acc + key_words[acc[1:0]]));
      end
    end
    res.result_first  = y;
    res.result_second = z;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0000_0000;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_blocks.size() == 0) begin
        $error("result with nothing outstanding: %h", rsp_o);
        n_errors++;
      end else begin
        want = expected_blocks.pop_front();
        n_checked++;
        if (rsp_o.result_first !== want.result_first) begin
          $error("result_first: expected %h, actual %h", want.result_first,
                 rsp_o.result_first);
          n_errors++;
        end
        if (rsp_o.result_second !== want.result_second) begin
          $error("result_second: expected %h, actual %h", want.result_second,
                 rsp_o.result_second);
          n_errors++;
        end
      end
    end
  end

  // start is left high after the transfer when gap is zero, so the next call
  // continues the stream without a dead cycle.
  task automatic send_block(input xtea_pkg::req_t blk, input int unsigned gap);
    xtea_pkg::rsp_t res;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= blk;
    do @(posedge clk_i); while (busy);
    res = xtea_transform(blk);
    expected_blocks.push_back(res);
    if (blk.req_type == DirEncipher) begin
      n_encipher++;
      recent_cipher.push_back({res.result_first, res.result_second});
      if (recent_cipher.size() > 16) void'(recent_cipher.pop_front());
    end else begin
      n_decipher++;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_words(input logic dir, input logic [31:0] w0, input logic [31:0] w1);
    xtea_pkg::req_t blk;
    blk.req_type    = dir;
    blk.word_first  = w0;
    blk.word_second = w1;
    send_block(blk, pick_gap());
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
  endtask

  // Only called with nothing in flight.
  task automatic write_key(input logic [xtea_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_key_writes++;
    if (idx <= xtea_pkg::RegKeyWord3) begin
      key_words[idx[1:0]] = data;
      recent_cipher.delete();
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    drain_results();
    write_key(xtea_pkg::RegKeyWord0, k0);
    write_key(xtea_pkg::RegKeyWord1, k1);
    write_key(xtea_pkg::RegKeyWord2, k2);
    write_key(xtea_pkg::RegKeyWord3, k3);
  endtask

  task automatic test_reset_key();
    send_words(DirEncipher, 32'h0000_0000, 32'h0000_0000);
    send_words(DirDecipher, 32'h0000_0000, 32'h0000_0000);
    send_words(DirEncipher, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_words(DirDecipher, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_extreme_keys();
    load_key('1, '1, '1, '1);
    send_words(DirEncipher, 32'h0000_0000, 32'hFFFF_FFFF);
    send_words(DirDecipher, 32'hFFFF_FFFF, 32'h0000_0000);
    send_words(DirEncipher, 32'h8000_0000, 32'h0000_0001);
    send_words(DirDecipher, 32'h0000_0001, 32'h8000_0000);
    load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_words(DirEncipher, 32'h5555_5555, 32'hAAAA_AAAA);
    send_words(DirDecipher, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // Distinct key words make a wrong choice of round key visible in either half-round.
  task automatic test_key_selection();
    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_words(DirEncipher, 32'h0000_0000, 32'h0000_0000);
    send_words(DirDecipher, 32'h0000_0000, 32'h0000_0000);
    send_words(DirEncipher, 32'h4142_4344, 32'h4546_4748);
    send_words(DirDecipher, recent_cipher[0][63:32], recent_cipher[0][31:0]);
  endtask

  // Writes to indexes beyond the key words must leave the key untouched.
  task automatic test_unused_index();
    drain_results();
    write_key(xtea_pkg::RegKeyWord3 + 1'b1, 32'hDEAD_BEEF);
    write_key('1, 32'hFFFF_FFFF);
    write_key(8'h80, 32'h1234_5678);
    send_words(DirEncipher, 32'h0000_0000, 32'h0000_0000);
    send_words(DirDecipher, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    xtea_pkg::req_t blk;
    logic [63:0]    c;
    bit             burst;
    for (int unsigned p = 0; p < Phases; p++) begin
      case (p)
        0: load_key('0, '0, '0, '0);
        1: load_key('1, '1, '1, '1);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      write_key(xtea_pkg::CfgIdxW'($urandom_range(4, 255)), $urandom);
      burst = (p == 3) || (p == 7);
      for (int unsigned i = 0; i < RandItems / Phases; i++) begin
        blk.req_type = 1'($urandom_range(0, 1));
        if (blk.req_type == DirDecipher && recent_cipher.size() != 0 &&
            $urandom_range(0, 1)) begin
          // Round trip: decipher a block enciphered under the same key.
          c = recent_cipher[$urandom_range(0, recent_cipher.size() - 1)];
          blk.word_first  = c[63:32];
          blk.word_second = c[31:0];
        end else begin
          blk.word_first  = pick_word();
          blk.word_second = pick_word();
        end
        send_block(blk, burst ? 0 : pick_gap());
        if (p == 5 && i == 50) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    n_errors     = 0;
    n_checked    = 0;
    n_encipher   = 0;
    n_decipher   = 0;
    n_key_writes = 0;
    n_cycles     = 0;
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_key();
    test_extreme_keys();
    test_key_selection();
    test_unused_index();
    test_random_traffic();

    drain_results();
    repeat (Latency + 8) @(posedge clk_i);
    $display("Sent %0d blocks (%0d encipher, %0d decipher), checked %0d results,",
             n_encipher + n_decipher, n_encipher, n_decipher, n_checked);
    $display("over %0d key register writes including unused indexes.", n_key_writes);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_stage.sv
hw/rtl/xtea_block_cipher_core.sv
tb/tb_xtea_block_cipher_core.sv
